### hdl/rbc_pkg.sv
package rbc_pkg;

    localparam int NUM_REGS_DEF   = 16;
    localparam int NUM_LOCALS_DEF = 16;
    localparam int NUM_FRAMES_DEF = 16;
    localparam int CODE_SPACE_DEF = 256;

    typedef logic [3:0] opcode_t;
    typedef logic [1:0] fault_t;

    localparam opcode_t OP_LDCONST = 4'd0;
    localparam opcode_t OP_LDLOCAL = 4'd1;
    localparam opcode_t OP_STLOCAL = 4'd2;
    localparam opcode_t OP_ADD     = 4'd3;
    localparam opcode_t OP_MUL     = 4'd4;
    localparam opcode_t OP_JMP     = 4'd5;
    localparam opcode_t OP_JMPZ    = 4'd6;
    localparam opcode_t OP_CALL    = 4'd7;
    localparam opcode_t OP_RET     = 4'd8;
    localparam opcode_t OP_HALT    = 4'd9;

    localparam fault_t FLT_NONE      = 2'd0;
    localparam fault_t FLT_OVERFLOW  = 2'd1;
    localparam fault_t FLT_UNDERFLOW = 2'd2;

    // byte modulo a constant n (1..256) through a 17-bit reciprocal scaled by 2^16
    function automatic logic [7:0] byte_mod(input logic [7:0] v, input logic [8:0] n,
                                            input logic [16:0] recip);
        logic [24:0] prod;
        logic [8:0]  q;
        logic [17:0] r;
        prod = 25'(v) * 25'(recip);
        q    = prod[24:16];
        r    = 18'(v) - 18'(q) * 18'(n);
        return r[7:0];
    endfunction

endpackage

### hdl/register_bytecode_core.sv
// register bytecode core
//
// one decoded instruction per request on the inst channel (op and three operand
// bytes), one result per request on the res channel (next fetch address, register
// write, register 0, halt flag and fault code).
//
// a request is taken into an input stage with its register file, local store and
// return address reads already started; execute then works from the input stage and
// loads the result register. throughput is one request per cycle while the result
// register can move, with the execute and its 32x32 multiply done combinationally.
//
// inst_ready stays high while the result register can move, so a new request is
// taken while a finished result still waits. when res_ready is low the result holds,
// the input stage holds one more request and then inst_ready drops.
//
// reset clears the register file and local store (through valid bits), the frame
// depth, instruction pointer and halt flag; no clearing pass is needed. after halt
// every request returns the stored address with no write and halted set.
module register_bytecode_core
    import rbc_pkg::*;
#(
    parameter int NUM_REGS   = NUM_REGS_DEF,
    parameter int NUM_LOCALS = NUM_LOCALS_DEF,
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int CODE_SPACE = CODE_SPACE_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               inst_valid,
    output logic               inst_ready,
    input  logic [3:0]         op,
    input  logic [7:0]         first_byte,
    input  logic [7:0]         second_byte,
    input  logic [7:0]         third_byte,
    output logic               res_valid,
    input  logic               res_ready,
    output logic [7:0]         next_ip,
    output logic               write_enable,
    output logic [3:0]         write_index,
    output logic signed [31:0] write_value,
    output logic signed [31:0] result_value,
    output logic               halted,
    output logic [1:0]         fault
);

    localparam int RW  = $clog2(NUM_REGS);
    localparam int LW  = (NUM_LOCALS > 1) ? $clog2(NUM_LOCALS) : 1;
    localparam int DW  = $clog2(NUM_FRAMES);
    localparam int IPW = $clog2(CODE_SPACE);
    localparam int LD  = NUM_FRAMES * NUM_LOCALS;
    localparam int LAW = $clog2(LD);

    localparam logic [16:0] REG_RECIP  = 17'((65536 + NUM_REGS - 1) / NUM_REGS);
    localparam logic [16:0] LOC_RECIP  = 17'((65536 + NUM_LOCALS - 1) / NUM_LOCALS);
    localparam logic [16:0] CODE_RECIP = 17'((65536 + CODE_SPACE - 1) / CODE_SPACE);

    function automatic logic [RW-1:0] rix(input logic [7:0] b);
        logic [7:0] m;
        m = byte_mod(b, 9'(NUM_REGS), REG_RECIP);
        return m[RW-1:0];
    endfunction

    function automatic logic [LW-1:0] lix(input logic [7:0] b);
        logic [7:0] m;
        m = byte_mod(b, 9'(NUM_LOCALS), LOC_RECIP);
        return m[LW-1:0];
    endfunction

    function automatic logic [IPW-1:0] cix(input logic [7:0] b);
        logic [7:0] m;
        m = byte_mod(b, 9'(CODE_SPACE), CODE_RECIP);
        return m[IPW-1:0];
    endfunction

    function automatic logic [LAW-1:0] laddr(input logic [DW-1:0] d, input logic [LW-1:0] l);
        return LAW'(d) * LAW'(NUM_LOCALS) + LAW'(l);
    endfunction

    function automatic logic [IPW-1:0] adv(input logic [IPW-1:0] ip, input logic [2:0] n);
        logic [IPW:0] s;
        s = {1'b0, ip} + (IPW+1)'(n);
        if (s >= (IPW+1)'(CODE_SPACE))
        begin
            s = s - (IPW+1)'(CODE_SPACE);
        end
        return s[IPW-1:0];
    endfunction

    // storage
    logic [31:0]     rf_mem [NUM_REGS];
    logic [31:0]     lm_mem [LD];
    logic [IPW-1:0]  ra_mem [NUM_FRAMES];

    // architectural state
    logic [NUM_REGS-1:0] rf_vld_reg, rf_vld_next;
    logic [LD-1:0]       lv_vld_reg, lv_vld_next;
    logic [DW-1:0]       depth_reg, depth_next;
    logic [IPW-1:0]      ip_reg, ip_next;
    logic                halt_reg, halt_next;
    logic [31:0]         reg0_reg, reg0_next;

    // input stage
    logic                s1_vld_reg, s1_vld_next;
    opcode_t             s1_op_reg;
    logic [7:0]          s1_b1_reg, s1_b2_reg;
    logic [31:0]         rfa_mem_reg, rfb_mem_reg, lm_mem_reg;
    logic [31:0]         rfa_ovv_reg, rfb_ovv_reg, lm_ovv_reg;
    logic                rfa_ovr_reg, rfb_ovr_reg, lm_ovr_reg;
    logic [IPW-1:0]      ra_mem_reg, ra_ovv_reg;
    logic                ra_ovr_reg;

    // result stage
    logic                res_vld_reg, res_vld_next;
    logic [7:0]          nip_out_reg;
    logic                we_out_reg;
    logic [3:0]          widx_out_reg;
    logic [31:0]         wval_out_reg, r0_out_reg;
    logic                halt_out_reg;
    fault_t              flt_out_reg;

    logic                exec_go, load;
    logic [31:0]         opa, opb, locv;
    logic [IPW-1:0]      rav;
    logic                we;
    logic [RW-1:0]       widx;
    logic [31:0]         wval;
    fault_t              flt;
    logic                lm_we, ra_we, call_ok;
    logic [LAW-1:0]      lm_waddr, lm_raddr;
    logic [RW-1:0]       a_idx, b_idx;
    logic [DW-1:0]       ra_raddr;
    logic                fwd_a, fwd_b, fwd_l, fwd_r;

    assign exec_go    = s1_vld_reg && (!res_vld_reg || res_ready);
    assign inst_ready = !s1_vld_reg || exec_go;
    assign load       = inst_valid && inst_ready;

    assign opa  = rfa_ovr_reg ? rfa_ovv_reg : rfa_mem_reg;
    assign opb  = rfb_ovr_reg ? rfb_ovv_reg : rfb_mem_reg;
    assign locv = lm_ovr_reg ? lm_ovv_reg : lm_mem_reg;
    assign rav  = ra_ovr_reg ? ra_ovv_reg : ra_mem_reg;

    assign lm_waddr = laddr(depth_reg, lix(s1_b1_reg));

    // execute
    always_comb
    begin
        we         = 1'b0;
        widx       = '0;
        wval       = '0;
        flt        = FLT_NONE;
        lm_we      = 1'b0;
        ra_we      = 1'b0;
        call_ok    = 1'b0;
        ip_next    = ip_reg;
        halt_next  = halt_reg;
        depth_next = depth_reg;
        if (exec_go && !halt_reg)
        begin
            ip_next = adv(ip_reg, 3'd1);
            case (s1_op_reg)
                OP_LDCONST:
                begin
                    we      = 1'b1;
                    widx    = rix(s1_b1_reg);
                    wval    = 32'(s1_b2_reg);
                    ip_next = adv(ip_reg, 3'd3);
                end
                OP_LDLOCAL:
                begin
                    we      = 1'b1;
                    widx    = rix(s1_b1_reg);
                    wval    = locv;
                    ip_next = adv(ip_reg, 3'd3);
                end
                OP_STLOCAL:
                begin
                    lm_we   = 1'b1;
                    ip_next = adv(ip_reg, 3'd3);
                end
                OP_ADD:
                begin
                    we      = 1'b1;
                    widx    = rix(s1_b1_reg);
                    wval    = opa + opb;
                    ip_next = adv(ip_reg, 3'd4);
                end
                OP_MUL:
                begin
                    we      = 1'b1;
                    widx    = rix(s1_b1_reg);
                    wval    = opa * opb;
                    ip_next = adv(ip_reg, 3'd4);
                end
                OP_JMP:
                begin
                    ip_next = cix(s1_b1_reg);
                end
                OP_JMPZ:
                begin
                    ip_next = (opa == '0) ? cix(s1_b2_reg) : adv(ip_reg, 3'd3);
                end
                OP_CALL:
                begin
                    if (depth_reg == DW'(NUM_FRAMES - 1))
                    begin
                        flt     = FLT_OVERFLOW;
                        ip_next = adv(ip_reg, 3'd2);
                    end
                    else
                    begin
                        call_ok    = 1'b1;
                        ra_we      = 1'b1;
                        depth_next = depth_reg + DW'(1);
                        ip_next    = cix(s1_b1_reg);
                    end
                end
                OP_RET:
                begin
                    if (depth_reg == '0)
                    begin
                        flt = FLT_UNDERFLOW;
                    end
                    else
                    begin
                        depth_next = depth_reg - DW'(1);
                        ip_next    = rav;
                    end
                end
                OP_HALT:
                begin
                    halt_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // valid bits and register 0 shadow
    always_comb
    begin
        rf_vld_next = rf_vld_reg;
        lv_vld_next = lv_vld_reg;
        reg0_next   = reg0_reg;
        if (we)
        begin
            rf_vld_next[widx] = 1'b1;
            if (widx == '0)
            begin
                reg0_next = wval;
            end
        end
        if (lm_we)
        begin
            lv_vld_next[lm_waddr] = 1'b1;
        end
        if (call_ok)
        begin
            for (int f = 0; f < NUM_FRAMES; f++)
            begin
                if (DW'(f) == depth_next)
                begin
                    lv_vld_next[f*NUM_LOCALS +: NUM_LOCALS] = '0;
                end
            end
        end
    end

    // read addresses for the incoming request, against the state after this cycle
    always_comb
    begin
        a_idx    = (op == OP_JMPZ) ? rix(first_byte) : rix(second_byte);
        b_idx    = rix(third_byte);
        lm_raddr = laddr(depth_next, lix(second_byte));
        ra_raddr = depth_next - DW'(1);
        fwd_a    = we && (widx == a_idx);
        fwd_b    = we && (widx == b_idx);
        fwd_l    = lm_we && (lm_waddr == lm_raddr);
        fwd_r    = ra_we && (depth_reg == ra_raddr);
    end

    assign s1_vld_next  = load || (s1_vld_reg && !exec_go);
    assign res_vld_next = exec_go || (res_vld_reg && !res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
            rf_vld_reg  <= '0;
            lv_vld_reg  <= '0;
            depth_reg   <= '0;
            ip_reg      <= '0;
            halt_reg    <= 1'b0;
            reg0_reg    <= '0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            res_vld_reg <= res_vld_next;
            rf_vld_reg  <= rf_vld_next;
            lv_vld_reg  <= lv_vld_next;
            depth_reg   <= depth_next;
            ip_reg      <= ip_next;
            halt_reg    <= halt_next;
            reg0_reg    <= reg0_next;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            rf_mem[widx] <= wval;
        end
        if (lm_we)
        begin
            lm_mem[lm_waddr] <= opa;
        end
        if (ra_we)
        begin
            ra_mem[depth_reg] <= adv(ip_reg, 3'd2);
        end
        if (load)
        begin
            rfa_mem_reg <= rf_mem[a_idx];
            rfb_mem_reg <= rf_mem[b_idx];
            lm_mem_reg  <= lm_mem[lm_raddr];
            ra_mem_reg  <= ra_mem[ra_raddr];
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_op_reg   <= op;
            s1_b1_reg   <= first_byte;
            s1_b2_reg   <= second_byte;
            rfa_ovr_reg <= fwd_a || !rf_vld_reg[a_idx];
            rfa_ovv_reg <= fwd_a ? wval : '0;
            rfb_ovr_reg <= fwd_b || !rf_vld_reg[b_idx];
            rfb_ovv_reg <= fwd_b ? wval : '0;
            lm_ovr_reg  <= fwd_l || call_ok || !lv_vld_reg[lm_raddr];
            lm_ovv_reg  <= fwd_l ? opa : '0;
            ra_ovr_reg  <= fwd_r;
            ra_ovv_reg  <= adv(ip_reg, 3'd2);
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            nip_out_reg  <= 8'(ip_next);
            we_out_reg   <= we;
            widx_out_reg <= 4'(widx);
            wval_out_reg <= wval;
            r0_out_reg   <= reg0_next;
            halt_out_reg <= halt_next;
            flt_out_reg  <= flt;
        end
    end

    assign res_valid    = res_vld_reg;
    assign next_ip      = nip_out_reg;
    assign write_enable = we_out_reg;
    assign write_index  = widx_out_reg;
    assign write_value  = wval_out_reg;
    assign result_value = r0_out_reg;
    assign halted       = halt_out_reg;
    assign fault        = flt_out_reg;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import rbc_pkg::*;

    localparam opcode_t OP_UNUSED_LO = 4'd10;
    localparam opcode_t OP_UNUSED_HI = 4'd15;

    localparam int RANDOM_BLOCKS = 8;
    localparam int BLOCK_ITEMS   = 240;
    localparam int MODE_SPAN     = 60;
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum int {MIX_BALANCED, MIX_CLIMB, MIX_UNWIND} call_mix_t;

    typedef struct packed {
        opcode_t    code;
        logic [7:0] arg1;
        logic [7:0] arg2;
        logic [7:0] arg3;
    } instr_t;

    typedef struct packed {
        logic [7:0]  next_ip;
        logic        we;
        logic [3:0]  widx;
        logic [31:0] wval;
        logic [31:0] r0;
        logic        halted;
        fault_t      fault;
    } outcome_t;

    typedef struct packed {
        instr_t   ins;
        logic     typed;
        outcome_t want;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               inst_valid = 1'b0;
    logic               inst_ready;
    logic [3:0]         op = '0;
    logic [7:0]         first_byte = '0;
    logic [7:0]         second_byte = '0;
    logic [7:0]         third_byte = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    logic [7:0]         next_ip;
    logic               write_enable;
    logic [3:0]         write_index;
    logic signed [31:0] write_value;
    logic signed [31:0] result_value;
    logic               halted;
    logic [1:0]         fault;

    // machine state mirrored by the predictor
    logic [31:0] vm_regs [NUM_REGS_DEF];
    logic [31:0] vm_locals [NUM_FRAMES_DEF * NUM_LOCALS_DEF];
    logic [7:0]  vm_ret_addr [NUM_FRAMES_DEF];
    logic [3:0]  vm_depth;
    logic [7:0]  vm_ip;
    logic        vm_halted;

    outcome_t  pending_results [$];
    stim_row_t directed_rows [$];
    int        errors = 0;
    int        cycle_count = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;

    register_bytecode_core dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
        res_ready <= ($urandom_range(0, 99) >= stall_pct);

    function automatic outcome_t execute_instruction(input instr_t ins);
        outcome_t   o;
        logic [7:0] nip;
        int         i;
        o = '0;
        if (!vm_halted)
        begin
            nip = vm_ip + 8'd1;
            case (ins.code)
                OP_LDCONST:
                begin
                    o.we = 1'b1;
                    o.widx = ins.arg1[3:0];
                    o.wval = {24'd0, ins.arg2};
                    nip = vm_ip + 8'd3;
                end
                OP_LDLOCAL:
                begin
                    o.we = 1'b1;
                    o.widx = ins.arg1[3:0];
                    o.wval = vm_locals[{vm_depth, ins.arg2[3:0]}];
                    nip = vm_ip + 8'd3;
                end
                OP_STLOCAL:
                begin
                    vm_locals[{vm_depth, ins.arg1[3:0]}] = vm_regs[ins.arg2[3:0]];
                    nip = vm_ip + 8'd3;
                end
                OP_ADD:
                begin
                    o.we = 1'b1;
                    o.widx = ins.arg1[3:0];
                    o.wval = vm_regs[ins.arg2[3:0]] + vm_regs[ins.arg3[3:0]];
                    nip = vm_ip + 8'd4;
                end
                OP_MUL:
                begin
                    o.we = 1'b1;
                    o.widx = ins.arg1[3:0];
                    o.wval = vm_regs[ins.arg2[3:0]] * vm_regs[ins.arg3[3:0]];
                    nip = vm_ip + 8'd4;
                end
                OP_JMP:
                    nip = ins.arg1;
                OP_JMPZ:
                    nip = (vm_regs[ins.arg1[3:0]] == 32'd0) ? ins.arg2 : vm_ip + 8'd3;
                OP_CALL:
                begin
                    if (vm_depth == 4'(NUM_FRAMES_DEF - 1))
                    begin
                        o.fault = FLT_OVERFLOW;
                        nip = vm_ip + 8'd2;
                    end
                    else
                    begin
                        vm_ret_addr[vm_depth] = vm_ip + 8'd2;
                        vm_depth = vm_depth + 4'd1;
                        for (i = 0; i < NUM_LOCALS_DEF; i++)
                            vm_locals[{vm_depth, 4'(i)}] = 32'd0;
                        nip = ins.arg1;
                    end
                end
                OP_RET:
                begin
                    if (vm_depth == 4'd0)
                        o.fault = FLT_UNDERFLOW;
                    else
                    begin
                        vm_depth = vm_depth - 4'd1;
                        nip = vm_ret_addr[vm_depth];
                    end
                end
                OP_HALT:
                    vm_halted = 1'b1;
                default:
                    ;
            endcase
            if (o.we)
                vm_regs[o.widx] = o.wval;
            vm_ip = nip;
        end
        o.next_ip = vm_ip;
        o.r0 = vm_regs[0];
        o.halted = vm_halted;
        return o;
    endfunction

    function automatic instr_t draw_instruction(input call_mix_t mix);
        instr_t ins;
        int     call_w;
        int     ret_w;
        int     pick;
        ins.arg1 = 8'($urandom_range(0, 255));
        ins.arg2 = 8'($urandom_range(0, 255));
        ins.arg3 = 8'($urandom_range(0, 255));
        case (mix)
            MIX_CLIMB:  begin call_w = 30; ret_w = 2;  end
            MIX_UNWIND: begin call_w = 2;  ret_w = 30; end
            default:    begin call_w = 8;  ret_w = 8;  end
        endcase
        pick = $urandom_range(0, 99);
        if (pick < call_w)
            ins.code = OP_CALL;
        else if (pick < call_w + ret_w)
            ins.code = OP_RET;
        else
        begin
            pick = $urandom_range(0, 79);
            if (pick < 18)
            begin
                ins.code = OP_LDCONST;
                if ($urandom_range(0, 4) == 0)
                    ins.arg2 = 8'd0;
            end
            else if (pick < 30)
                ins.code = OP_LDLOCAL;
            else if (pick < 42)
                ins.code = OP_STLOCAL;
            else if (pick < 54)
                ins.code = OP_ADD;
            else if (pick < 64)
                ins.code = OP_MUL;
            else if (pick < 69)
                ins.code = OP_JMP;
            else if (pick < 77)
                ins.code = OP_JMPZ;
            else
                ins.code = opcode_t'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
        return ins;
    endfunction

    task automatic add_row(input opcode_t code, input logic [7:0] a1, input logic [7:0] a2,
                           input logic [7:0] a3, input logic typed, input outcome_t want);
        stim_row_t row;
        row.ins = {code, a1, a2, a3};
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    task automatic issue_instruction(input instr_t ins, input logic typed, input outcome_t want);
        int       gap;
        outcome_t predicted;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            inst_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        inst_valid  <= 1'b1;
        op          <= ins.code;
        first_byte  <= ins.arg1;
        second_byte <= ins.arg2;
        third_byte  <= ins.arg3;
        do
            @(posedge clk);
        while (!inst_ready);
        predicted = execute_instruction(ins);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        outcome_t exp_r;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no request outstanding, next_ip %0h",
                         $time, next_ip);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                compare_field("next_ip", 32'(exp_r.next_ip), 32'(next_ip));
                compare_field("write_enable", 32'(exp_r.we), 32'(write_enable));
                compare_field("write_index", 32'(exp_r.widx), 32'(write_index));
                compare_field("write_value", exp_r.wval, write_value);
                compare_field("result_value", exp_r.r0, result_value);
                compare_field("halted", 32'(exp_r.halted), 32'(halted));
                compare_field("fault", 32'(exp_r.fault), 32'(fault));
            end
        end
    end

    initial
    begin
        int        blk;
        int        n;
        int        k;
        call_mix_t mix;
        for (k = 0; k < NUM_REGS_DEF; k++)
            vm_regs[k] = 32'd0;
        for (k = 0; k < NUM_FRAMES_DEF * NUM_LOCALS_DEF; k++)
            vm_locals[k] = 32'd0;
        for (k = 0; k < NUM_FRAMES_DEF; k++)
            vm_ret_addr[k] = 8'd0;
        vm_depth = 4'd0;
        vm_ip = 8'd0;
        vm_halted = 1'b0;
        mix = MIX_BALANCED;

        // state right after reset, constant extremes, return underflow
        add_row(OP_RET, 8'h00, 8'h00, 8'h00, 1'b1,
                {8'd1, 1'b0, 4'd0, 32'd0, 32'd0, 1'b0, FLT_UNDERFLOW});
        add_row(OP_LDCONST, 8'hFF, 8'hFF, 8'hFF, 1'b1,
                {8'd4, 1'b1, 4'd15, 32'd255, 32'd0, 1'b0, FLT_NONE});
        add_row(OP_LDCONST, 8'h10, 8'h80, 8'h00, 1'b1,
                {8'd7, 1'b1, 4'd0, 32'd128, 32'd128, 1'b0, FLT_NONE});
        add_row(OP_LDCONST, 8'hF0, 8'h00, 8'hAA, 1'b1,
                {8'd10, 1'b1, 4'd0, 32'd0, 32'd0, 1'b0, FLT_NONE});
        add_row(OP_ADD, 8'h01, 8'h0F, 8'h1F, 1'b0, '0);
        add_row(OP_MUL, 8'h02, 8'h01, 8'h01, 1'b0, '0);
        add_row(OP_STLOCAL, 8'hF3, 8'h02, 8'h00, 1'b0, '0);
        add_row(OP_LDLOCAL, 8'h03, 8'h03, 8'h00, 1'b0, '0);
        add_row(OP_JMPZ, 8'h00, 8'hAB, 8'h00, 1'b0, '0);
        add_row(OP_JMPZ, 8'h0F, 8'h00, 8'h00, 1'b0, '0);
        add_row(OP_JMP, 8'hFF, 8'h00, 8'h00, 1'b0, '0);
        add_row(OP_UNUSED_HI, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0);
        // nest to the deepest frame, then one call too many
        for (k = 1; k < NUM_FRAMES_DEF; k++)
            add_row(OP_CALL, 8'(17 * k), 8'h55, 8'h00, 1'b0, '0);
        add_row(OP_CALL, 8'h33, 8'h00, 8'h00, 1'b0, '0);
        add_row(OP_LDLOCAL, 8'h04, 8'h03, 8'h00, 1'b0, '0);
        add_row(OP_RET, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            issue_instruction(directed_rows[k].ins, directed_rows[k].typed,
                              directed_rows[k].want);

        for (blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            case (blk % 4)
                1:       begin idle_pct = 59; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 59; end
                3:       begin idle_pct = 35; stall_pct = 35; end
                default: begin idle_pct = 0;  stall_pct = 0;  end
            endcase
            // drain the pipeline once mid run
            if (blk == RANDOM_BLOCKS / 2)
            begin
                inst_valid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            for (n = 0; n < BLOCK_ITEMS; n++)
            begin
                if (n % MODE_SPAN == 0)
                    mix = call_mix_t'($urandom_range(0, 2));
                issue_instruction(draw_instruction(mix), 1'b0, '0);
            end
        end

        // halt, then requests that must be ignored
        issue_instruction({OP_HALT, 8'h5A, 8'hA5, 8'h3C}, 1'b0, '0);
        for (n = 0; n < 3; n++)
            issue_instruction(draw_instruction(MIX_BALANCED), 1'b0, '0);

        inst_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

### sim.f
hdl/rbc_pkg.sv
hdl/register_bytecode_core.sv
tb/testbench.sv
